// File: design/plom_pkg.sv
// ----------------------------------------------------------------------------
// plom_pkg
// Shared codes, reset values, state and command types for the price level
// order matcher.
// ----------------------------------------------------------------------------
package plom_pkg;

    localparam int ACT_W      = 3;
    localparam int ID_W       = 32;
    localparam int QTY_W      = 32;
    localparam int PRICE_W    = 10;
    localparam int BAND_W     = 8;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 10;

    localparam logic [ACT_W-1:0] ACT_BUY_LIMIT   = 3'd0;
    localparam logic [ACT_W-1:0] ACT_BUY_MARKET  = 3'd1;
    localparam logic [ACT_W-1:0] ACT_SELL_LIMIT  = 3'd2;
    localparam logic [ACT_W-1:0] ACT_SELL_MARKET = 3'd3;
    localparam logic [ACT_W-1:0] ACT_CANCEL      = 3'd4;

    localparam logic [2:0] KIND_BUY_LIMIT  = 3'd0;
    localparam logic [2:0] KIND_SELL_LIMIT = 3'd1;
    localparam logic [2:0] KIND_BUY_MKT    = 3'd2;
    localparam logic [2:0] KIND_SELL_MKT   = 3'd3;
    localparam logic [2:0] KIND_BUY_MLIM   = 3'd4;
    localparam logic [2:0] KIND_SELL_MLIM  = 3'd5;
    localparam logic [2:0] KIND_CANCEL     = 3'd6;
    localparam logic [2:0] KIND_REJECT     = 3'd7;

    localparam logic [CFG_IDX_W-1:0] CFG_BAND      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_START_BID = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_START_ASK = 2'd2;

    localparam logic [BAND_W-1:0]  BAND_RST      = 8'd8;
    localparam logic [PRICE_W-1:0] START_BID_RST = 10'd500;
    localparam logic [PRICE_W-1:0] START_ASK_RST = 10'd501;

    typedef enum logic [4:0] {
        ST_CLEAR, ST_IDLE, ST_DECODE,
        ST_LIM_RD, ST_LIM_WR, ST_CAN_RD, ST_CAN_WR,
        ST_SWP_RD, ST_SWP_CK, ST_SWP_END,
        ST_RSA_RD, ST_RSA_CK, ST_RSB_RD, ST_RSB_CK,
        ST_FINISH, ST_PART_RD, ST_PART_WR, ST_EMIT
    } plom_state_t;

    typedef enum logic [1:0] {
        DEC_EMIT, DEC_REST, DEC_MARKET, DEC_CANCEL
    } plom_dec_t;

    typedef enum logic [2:0] {
        ADDR_CLR, ADDR_PRICE, ADDR_P, ADDR_ASK, ADDR_BID, ADDR_LIM
    } plom_addr_t;

    typedef enum logic [2:0] {
        WD_ZERO, WD_ADD, WD_SUB, WD_SUB_LEFT, WD_LEFT
    } plom_wsel_t;

    typedef struct packed {
        logic       capture;
        logic       decode;
        logic       wr;
        plom_addr_t rd_sel;
        plom_addr_t wr_sel;
        plom_wsel_t wsel;
        logic       move_best;
        logic       swp_step;
        logic       swp_end;
        logic       ask_inc;
        logic       bid_dec;
        logic       rest_load;
        logic       clr_inc;
        logic       emit;
    } plom_cmd_t;

    typedef struct packed {
        plom_dec_t dec;
        logic      is_sell;
        logic      clr_done;
        logic      swp_go;
        logic      rsa_go;
        logic      rsb_go;
        logic      can_zero;
        logic      can_ask;
        logic      can_bid;
        logic      left_zero;
        logic      past;
        logic      out_free;
    } plom_sts_t;

endpackage

// File: design/plom_ram.sv
// ----------------------------------------------------------------------------
// plom_ram
// Simple dual port RAM, one write and one read port, registered read.
// ----------------------------------------------------------------------------
module plom_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// File: design/plom_datapath.sv
// ----------------------------------------------------------------------------
// plom_datapath
// Order registers, book pointers, level depth memory, sweep arithmetic and
// the result register.
// ----------------------------------------------------------------------------
module plom_datapath #(
    parameter int PRICE_LEVELS = 1024,
    parameter int QTY_BITS     = 32
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  plom_pkg::plom_cmd_t            cmd,
    output plom_pkg::plom_sts_t            sts,
    input  logic [plom_pkg::ACT_W-1:0]     s_action,
    input  logic [plom_pkg::ID_W-1:0]      s_order_id,
    input  logic [plom_pkg::QTY_W-1:0]     s_order_qty,
    input  logic [plom_pkg::PRICE_W-1:0]   s_order_price,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [2:0]                     m_result_kind,
    output logic [plom_pkg::ID_W-1:0]      m_result_id,
    output logic [plom_pkg::QTY_W-1:0]     m_result_qty,
    output logic [plom_pkg::PRICE_W-1:0]   m_result_price,
    output logic [plom_pkg::QTY_W-1:0]     m_resting_qty,
    output logic [plom_pkg::PRICE_W-1:0]   m_resting_price,
    input  logic                           cfg_valid,
    input  logic [plom_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [plom_pkg::CFG_DATA_W-1:0] cfg_data
);
    import plom_pkg::*;

    localparam int LW = $clog2(PRICE_LEVELS);
    localparam int AW = ((LW > 9) ? LW : 9) + 2;
    localparam int QW = QTY_BITS;
    localparam int XW = (QW > QTY_W) ? QW : QTY_W;
    localparam logic signed [AW-1:0] TOP_A = AW'(PRICE_LEVELS - 1);
    localparam logic [XW-1:0] QMAX_X = XW'({QW{1'b1}});

    function automatic logic [LW-1:0] clamp_lvl(input logic signed [AW-1:0] v);
        logic [LW-1:0] r;
        if (v < 0) begin
            r = '0;
        end else if (v > TOP_A) begin
            r = TOP_A[LW-1:0];
        end else begin
            r = v[LW-1:0];
        end
        return r;
    endfunction

    function automatic logic [QTY_W-1:0] to_out(input logic [QW-1:0] v);
        logic [XW-1:0] t;
        t = XW'(v);
        return t[QTY_W-1:0];
    endfunction

    function automatic logic [PRICE_W-1:0] lvl_out(input logic [LW-1:0] v);
        logic [AW-1:0] t;
        t = AW'(v);
        return t[PRICE_W-1:0];
    endfunction

    logic [ACT_W-1:0]   act_reg;
    logic [ID_W-1:0]    id_reg;
    logic [QW-1:0]      qty_reg;
    logic [PRICE_W-1:0] price_reg;
    logic               sell_reg;
    logic signed [AW-1:0] p_reg;
    logic [LW-1:0]      lim_reg;
    logic [QW-1:0]      left_reg;
    logic               past_reg;
    logic [LW-1:0]      bid_reg;
    logic [LW-1:0]      ask_reg;
    logic [BAND_W-1:0]  band_reg;
    logic [LW-1:0]      clr_cnt_reg;
    logic [2:0]         res_kind_reg;
    logic [QTY_W-1:0]   res_qty_reg;
    logic [PRICE_W-1:0] res_price_reg;
    logic [QTY_W-1:0]   rest_qty_reg;
    logic [PRICE_W-1:0] rest_price_reg;
    logic               m_valid_reg;
    logic [2:0]         m_kind_reg;
    logic [ID_W-1:0]    m_id_reg;
    logic [QTY_W-1:0]   m_qty_reg;
    logic [PRICE_W-1:0] m_price_reg;
    logic [QTY_W-1:0]   m_rqty_reg;
    logic [PRICE_W-1:0] m_rprice_reg;

    logic signed [AW-1:0] price_a, bid_a, ask_a, band_a, lim_a, lim_raw;
    logic               in_table;
    plom_dec_t          dec;
    logic [2:0]         kind_d;
    logic [LW-1:0]      lim_c;
    logic [XW-1:0]      q_ext;
    logic [QW-1:0]      q_sat;
    logic [QW-1:0]      rd_data;
    logic [QW:0]        add_sum;
    logic [QW-1:0]      add_val, sub_val, sub_left_val;
    logic [QW-1:0]      wr_data;
    logic [LW-1:0]      wr_addr, rd_addr;
    logic [LW-1:0]      price_l;

    assign price_a = signed'(AW'(price_reg));
    assign bid_a   = signed'(AW'(bid_reg));
    assign ask_a   = signed'(AW'(ask_reg));
    assign band_a  = signed'(AW'(band_reg));
    assign lim_a   = signed'(AW'(lim_reg));
    assign in_table = price_a <= TOP_A;
    assign price_l = clamp_lvl(price_a);

    assign q_ext = XW'(s_order_qty);
    assign q_sat = (q_ext > QMAX_X) ? QMAX_X[QW-1:0] : q_ext[QW-1:0];

    always_comb begin
        dec    = DEC_EMIT;
        kind_d = KIND_REJECT;
        unique case (act_reg)
            ACT_BUY_LIMIT: begin
                if (in_table && (price_a <= bid_a || price_a < ask_a)) begin
                    dec    = DEC_REST;
                    kind_d = KIND_BUY_LIMIT;
                end else if (in_table && price_a < ask_a + band_a) begin
                    dec    = DEC_MARKET;
                    kind_d = KIND_BUY_MKT;
                end
            end
            ACT_BUY_MARKET: begin
                dec    = DEC_MARKET;
                kind_d = KIND_BUY_MKT;
            end
            ACT_SELL_LIMIT: begin
                if (in_table && (price_a >= ask_a || price_a > bid_a)) begin
                    dec    = DEC_REST;
                    kind_d = KIND_SELL_LIMIT;
                end else if (in_table && price_a > bid_a - band_a) begin
                    dec    = DEC_MARKET;
                    kind_d = KIND_SELL_MKT;
                end
            end
            ACT_SELL_MARKET: begin
                dec    = DEC_MARKET;
                kind_d = KIND_SELL_MKT;
            end
            ACT_CANCEL: begin
                kind_d = KIND_CANCEL;
                if (in_table) begin
                    dec = DEC_CANCEL;
                end
            end
            default: begin
                dec    = DEC_EMIT;
                kind_d = KIND_REJECT;
            end
        endcase
    end

    always_comb begin
        if (!sell_reg) begin
            lim_raw = (price_reg == '0 || price_a < ask_a) ? ask_a + band_a : price_a;
        end else begin
            lim_raw = (price_reg == '0 || price_a > bid_a) ? bid_a - band_a : price_a;
        end
    end
    assign lim_c = clamp_lvl(lim_raw);

    assign add_sum      = {1'b0, rd_data} + {1'b0, qty_reg};
    assign add_val      = add_sum[QW] ? {QW{1'b1}} : add_sum[QW-1:0];
    assign sub_val      = (qty_reg >= rd_data) ? '0 : rd_data - qty_reg;
    assign sub_left_val = (left_reg >= rd_data) ? '0 : rd_data - left_reg;

    always_comb begin
        unique case (cmd.wsel)
            WD_ZERO:     wr_data = '0;
            WD_ADD:      wr_data = add_val;
            WD_SUB:      wr_data = sub_val;
            WD_SUB_LEFT: wr_data = sub_left_val;
            WD_LEFT:     wr_data = left_reg;
            default:     wr_data = '0;
        endcase
    end

    always_comb begin
        unique case (cmd.wr_sel)
            ADDR_CLR:   wr_addr = clr_cnt_reg;
            ADDR_PRICE: wr_addr = price_l;
            ADDR_P:     wr_addr = clamp_lvl(p_reg);
            ADDR_ASK:   wr_addr = ask_reg;
            ADDR_BID:   wr_addr = bid_reg;
            ADDR_LIM:   wr_addr = lim_reg;
            default:    wr_addr = clr_cnt_reg;
        endcase
    end

    always_comb begin
        unique case (cmd.rd_sel)
            ADDR_CLR:   rd_addr = clr_cnt_reg;
            ADDR_PRICE: rd_addr = price_l;
            ADDR_P:     rd_addr = clamp_lvl(p_reg);
            ADDR_ASK:   rd_addr = ask_reg;
            ADDR_BID:   rd_addr = bid_reg;
            ADDR_LIM:   rd_addr = lim_reg;
            default:    rd_addr = clr_cnt_reg;
        endcase
    end

    plom_ram #(
        .WIDTH (QW),
        .DEPTH (PRICE_LEVELS)
    ) u_depth (
        .aclk  (aclk),
        .we    (cmd.wr),
        .waddr (wr_addr),
        .wdata (wr_data),
        .raddr (rd_addr),
        .rdata (rd_data)
    );

    always_comb begin
        sts.dec       = dec;
        sts.is_sell   = sell_reg;
        sts.clr_done  = clr_cnt_reg == LW'(PRICE_LEVELS - 1);
        sts.swp_go    = (sell_reg ? (p_reg >= lim_a) : (p_reg <= lim_a))
                        && left_reg >= rd_data;
        sts.rsa_go    = rd_data == '0 && ask_a < TOP_A - band_a;
        sts.rsb_go    = rd_data == '0 && bid_a > band_a;
        sts.can_zero  = sub_val == '0;
        sts.can_ask   = price_a == ask_a;
        sts.can_bid   = price_a == bid_a;
        sts.left_zero = left_reg == '0;
        sts.past      = past_reg;
        sts.out_free  = !m_valid_reg || m_ready;
    end

    // order capture and sweep registers
    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            act_reg   <= s_action;
            id_reg    <= s_order_id;
            qty_reg   <= q_sat;
            price_reg <= s_order_price;
            sell_reg  <= s_action == ACT_SELL_LIMIT || s_action == ACT_SELL_MARKET;
        end
        if (cmd.decode) begin
            lim_reg        <= lim_c;
            p_reg          <= sell_reg ? bid_a : ask_a;
            left_reg       <= qty_reg;
            res_kind_reg   <= kind_d;
            res_qty_reg    <= to_out(qty_reg);
            res_price_reg  <= (dec == DEC_MARKET) ? lvl_out(sell_reg ? bid_reg : ask_reg)
                                                  : price_reg;
            rest_qty_reg   <= '0;
            rest_price_reg <= '0;
        end
        if (cmd.swp_step) begin
            left_reg <= left_reg - rd_data;
            p_reg    <= sell_reg ? p_reg - AW'(1) : p_reg + AW'(1);
        end
        if (cmd.swp_end) begin
            past_reg <= sell_reg ? (p_reg < lim_a) : (p_reg > lim_a);
        end
        if (cmd.rest_load) begin
            res_kind_reg   <= sell_reg ? KIND_SELL_MLIM : KIND_BUY_MLIM;
            res_qty_reg    <= to_out(qty_reg - left_reg);
            rest_qty_reg   <= to_out(left_reg);
            rest_price_reg <= lvl_out(lim_reg);
        end
        if (cmd.emit) begin
            m_kind_reg   <= res_kind_reg;
            m_id_reg     <= id_reg;
            m_qty_reg    <= res_qty_reg;
            m_price_reg  <= res_price_reg;
            m_rqty_reg   <= rest_qty_reg;
            m_rprice_reg <= rest_price_reg;
        end
    end

    // book pointers, configuration, clear counter, result valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bid_reg     <= clamp_lvl(signed'(AW'(START_BID_RST)));
            ask_reg     <= clamp_lvl(signed'(AW'(START_ASK_RST)));
            band_reg    <= BAND_RST;
            clr_cnt_reg <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cmd.clr_inc) begin
                clr_cnt_reg <= clr_cnt_reg + LW'(1);
            end
            if (cmd.move_best) begin
                if (!sell_reg && price_a > bid_a) begin
                    bid_reg <= price_l;
                end
                if (sell_reg && price_a < ask_a) begin
                    ask_reg <= price_l;
                end
            end
            if (cmd.swp_end) begin
                if (sell_reg) begin
                    bid_reg <= clamp_lvl(p_reg);
                end else begin
                    ask_reg <= clamp_lvl(p_reg);
                end
            end
            if (cmd.ask_inc) begin
                ask_reg <= ask_reg + LW'(1);
            end
            if (cmd.bid_dec) begin
                bid_reg <= bid_reg - LW'(1);
            end
            if (cmd.rest_load) begin
                if (sell_reg) begin
                    ask_reg <= lim_reg;
                end else begin
                    bid_reg <= lim_reg;
                end
            end
            if (cfg_valid) begin
                unique case (cfg_index)
                    CFG_BAND:      band_reg <= cfg_data[BAND_W-1:0];
                    CFG_START_BID: bid_reg  <= clamp_lvl(signed'(AW'(cfg_data)));
                    CFG_START_ASK: ask_reg  <= clamp_lvl(signed'(AW'(cfg_data)));
                    default: ;
                endcase
            end
            if (cmd.emit) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_result_kind   = m_kind_reg;
    assign m_result_id     = m_id_reg;
    assign m_result_qty    = m_qty_reg;
    assign m_result_price  = m_price_reg;
    assign m_resting_qty   = m_rqty_reg;
    assign m_resting_price = m_rprice_reg;

endmodule

// File: design/plom_ctrl.sv
// ----------------------------------------------------------------------------
// plom_ctrl
// Sequencer: clearing pass, decode, read-modify-write of a level, sweep,
// best price rescans and result hand-off.
// ----------------------------------------------------------------------------
module plom_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  plom_pkg::plom_sts_t sts,
    output plom_pkg::plom_cmd_t cmd
);
    import plom_pkg::*;

    plom_state_t state_reg, state_next;
    logic        post_sweep_reg, post_sweep_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_CLEAR;
            post_sweep_reg <= 1'b0;
        end else begin
            state_reg      <= state_next;
            post_sweep_reg <= post_sweep_next;
        end
    end

    always_comb begin
        cmd             = '0;
        s_ready         = 1'b0;
        state_next      = state_reg;
        post_sweep_next = post_sweep_reg;
        unique case (state_reg)
            ST_CLEAR: begin
                cmd.wr      = 1'b1;
                cmd.wr_sel  = ADDR_CLR;
                cmd.wsel    = WD_ZERO;
                cmd.clr_inc = 1'b1;
                if (sts.clr_done) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.capture = 1'b1;
                    state_next  = ST_DECODE;
                end
            end
            ST_DECODE: begin
                cmd.decode = 1'b1;
                unique case (sts.dec)
                    DEC_EMIT:   state_next = ST_EMIT;
                    DEC_REST:   state_next = ST_LIM_RD;
                    DEC_CANCEL: state_next = ST_CAN_RD;
                    DEC_MARKET: begin
                        state_next      = ST_SWP_RD;
                        post_sweep_next = 1'b1;
                    end
                    default:    state_next = ST_EMIT;
                endcase
            end
            ST_LIM_RD: begin
                cmd.rd_sel = ADDR_PRICE;
                state_next = ST_LIM_WR;
            end
            ST_LIM_WR: begin
                cmd.wr        = 1'b1;
                cmd.wr_sel    = ADDR_PRICE;
                cmd.wsel      = WD_ADD;
                cmd.move_best = 1'b1;
                state_next    = ST_EMIT;
            end
            ST_CAN_RD: begin
                cmd.rd_sel = ADDR_PRICE;
                state_next = ST_CAN_WR;
            end
            ST_CAN_WR: begin
                cmd.wr     = 1'b1;
                cmd.wr_sel = ADDR_PRICE;
                cmd.wsel   = WD_SUB;
                priority if (sts.can_zero && sts.can_ask) begin
                    state_next = ST_RSA_RD;
                end else if (sts.can_zero && sts.can_bid) begin
                    state_next = ST_RSB_RD;
                end else begin
                    state_next = ST_EMIT;
                end
            end
            ST_SWP_RD: begin
                cmd.rd_sel = ADDR_P;
                state_next = ST_SWP_CK;
            end
            ST_SWP_CK: begin
                if (sts.swp_go) begin
                    cmd.wr       = 1'b1;
                    cmd.wr_sel   = ADDR_P;
                    cmd.wsel     = WD_ZERO;
                    cmd.swp_step = 1'b1;
                    state_next   = ST_SWP_RD;
                end else begin
                    state_next = ST_SWP_END;
                end
            end
            ST_SWP_END: begin
                cmd.swp_end = 1'b1;
                state_next  = sts.is_sell ? ST_RSB_RD : ST_RSA_RD;
            end
            ST_RSA_RD: begin
                cmd.rd_sel = ADDR_ASK;
                state_next = ST_RSA_CK;
            end
            ST_RSA_CK: begin
                if (sts.rsa_go) begin
                    cmd.ask_inc = 1'b1;
                    state_next  = ST_RSA_RD;
                end else begin
                    state_next = post_sweep_reg ? ST_FINISH : ST_EMIT;
                end
            end
            ST_RSB_RD: begin
                cmd.rd_sel = ADDR_BID;
                state_next = ST_RSB_CK;
            end
            ST_RSB_CK: begin
                if (sts.rsb_go) begin
                    cmd.bid_dec = 1'b1;
                    state_next  = ST_RSB_RD;
                end else begin
                    state_next = post_sweep_reg ? ST_FINISH : ST_EMIT;
                end
            end
            ST_FINISH: begin
                post_sweep_next = 1'b0;
                priority if (sts.left_zero) begin
                    state_next = ST_EMIT;
                end else if (!sts.past) begin
                    state_next = ST_PART_RD;
                end else begin
                    cmd.wr        = 1'b1;
                    cmd.wr_sel    = ADDR_LIM;
                    cmd.wsel      = WD_LEFT;
                    cmd.rest_load = 1'b1;
                    state_next    = ST_EMIT;
                end
            end
            ST_PART_RD: begin
                cmd.rd_sel = sts.is_sell ? ADDR_BID : ADDR_ASK;
                state_next = ST_PART_WR;
            end
            ST_PART_WR: begin
                cmd.wr     = 1'b1;
                cmd.wr_sel = sts.is_sell ? ADDR_BID : ADDR_ASK;
                cmd.wsel   = WD_SUB_LEFT;
                state_next = sts.is_sell ? ST_RSB_RD : ST_RSA_RD;
            end
            ST_EMIT: begin
                if (sts.out_free) begin
                    cmd.emit   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

endmodule

// File: design/price_level_order_matcher.sv
// ----------------------------------------------------------------------------
// price_level_order_matcher
// Limit order book over per-level resting quantity with best bid/ask.
// ----------------------------------------------------------------------------
// One order at a time, one result beat per order. After reset a clearing pass
// zeroes the depth memory level by level, during which no order is taken
// (config writes are). A rejected order goes from decode straight to its
// result. A resting limit order or a cancel reads its level and writes it
// back; a cancel that empties the best level then rescans for the new best.
// A market sweep reads and clears each level it crosses, then rescans the
// best price; a partial fill of the last level takes the remainder out of
// that level and rescans again. The depth memory has a single read port,
// one level per read. The result is registered, so the next order is taken
// while it waits.
// ----------------------------------------------------------------------------
module price_level_order_matcher #(
    parameter int PRICE_LEVELS = 1024,
    parameter int QTY_BITS     = 32
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [plom_pkg::ACT_W-1:0]      s_action,
    input  logic [plom_pkg::ID_W-1:0]       s_order_id,
    input  logic [plom_pkg::QTY_W-1:0]      s_order_qty,
    input  logic [plom_pkg::PRICE_W-1:0]    s_order_price,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [2:0]                      m_result_kind,
    output logic [plom_pkg::ID_W-1:0]       m_result_id,
    output logic [plom_pkg::QTY_W-1:0]      m_result_qty,
    output logic [plom_pkg::PRICE_W-1:0]    m_result_price,
    output logic [plom_pkg::QTY_W-1:0]      m_resting_qty,
    output logic [plom_pkg::PRICE_W-1:0]    m_resting_price,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [plom_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [plom_pkg::CFG_DATA_W-1:0] cfg_data
);
    import plom_pkg::*;

    plom_cmd_t cmd;
    plom_sts_t sts;

    assign cfg_ready = 1'b1;

    plom_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    plom_datapath #(
        .PRICE_LEVELS (PRICE_LEVELS),
        .QTY_BITS     (QTY_BITS)
    ) u_dp (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cmd             (cmd),
        .sts             (sts),
        .s_action        (s_action),
        .s_order_id      (s_order_id),
        .s_order_qty     (s_order_qty),
        .s_order_price   (s_order_price),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_result_kind   (m_result_kind),
        .m_result_id     (m_result_id),
        .m_result_qty    (m_result_qty),
        .m_result_price  (m_result_price),
        .m_resting_qty   (m_resting_qty),
        .m_resting_price (m_resting_price),
        .cfg_valid       (cfg_valid),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data)
    );

endmodule
